/* design/utf8_decode_with_replacement_unit_assert.svh */
// Assertion macros for the UTF-8 decode unit.
// Included by the top level; expects clk and rst_n in scope.
`ifndef UTF8_DECODE_WITH_REPLACEMENT_UNIT_ASSERT_SVH
`define UTF8_DECODE_WITH_REPLACEMENT_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UTF8D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/utf8d_pkg.sv */
// Shared types and constants for the UTF-8 decode unit.
// No dependencies; used by the lane, merge and top-level modules.
package utf8d_pkg;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [7:0]  CONT_LOW       = 8'h80;
  localparam logic [7:0]  CONT_HIGH      = 8'hBF;
  localparam logic [5:0]  PAYLOAD_MASK   = 6'b111111;
  localparam logic [7:0]  LEAD_E0        = 8'hE0;
  localparam logic [7:0]  LEAD_ED        = 8'hED;
  localparam logic [7:0]  LEAD_F0        = 8'hF0;
  localparam logic [7:0]  LEAD_F4        = 8'hF4;
  localparam logic [2:0]  MAX_WINDOW     = 3'd4;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  // What one lane finds out about its window byte.
  typedef struct packed {
    logic       is_cont;   // 80..BF
    logic       ge_a0;     // at least A0
    logic       ge_90;     // at least 90
    logic       le_9f;     // at most 9F
    logic       le_8f;     // at most 8F
    logic [5:0] payload;   // low six bits
  } lane_info_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  consumed;
    status_t     status;
  } result_t;

endpackage

/* design/utf8_decode_with_replacement_unit.sv */
// UTF-8 decode unit with U+FFFD replacement, one four-byte window per item.
// Depends on utf8d_pkg, utf8d_lane, utf8d_merge and the assertion header.
//
// Usage:
//   The input channel (in_tvalid/in_tready/in_tdata) carries one window per
//   item: four bytes and a count of how many are present. The result channel
//   (out_tvalid/out_tready/out_tdata/out_tuser) returns one item per window:
//   the decoded code point, the number of bytes taken, and a status in tuser.
//   The caller advances its byte stream by the consumed count.
//   Four byte lanes classify the window bytes in parallel and a merge stage
//   forms the result combinationally, ahead of the output register. An item
//   taken into an empty or draining output register shows on out_tvalid in
//   the next cycle. Throughput is one item per cycle while out_tready is high.
//   A skid register behind the output register lets one more item be accepted
//   while a result waits; in_tready drops only while both are full, and the
//   two held results leave in order once out_tready returns.
//   Reset (rst_n low, synchronous) empties both registers; nothing else is
//   kept between items.
module utf8_decode_with_replacement_unit
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // byte0[7:0], byte1[15:8], byte2[23:16],
                                  // byte3[31:24], avail_count[34:32], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // code_point[20:0], consumed[23:21]
  output logic [1:0]  out_tuser   // status[1:0]
);

  `include "utf8_decode_with_replacement_unit_assert.svh"

  logic [7:0]  win_byte [4];
  lane_info_t  lane_info [4];
  result_t     new_result;

  logic        out_valid_r, out_valid_nxt;
  result_t     out_data_r, out_data_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  result_t     skid_data_r, skid_data_nxt;
  logic        in_fire;
  logic        out_fire;

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_lane
      assign win_byte[g] = in_tdata[8*g +: 8];
      utf8d_lane u_lane (
        .byte_in (win_byte[g]),
        .info    (lane_info[g])
      );
    end
  endgenerate

  utf8d_merge u_merge (
    .lead        (win_byte[0]),
    .avail_count (in_tdata[34:32]),
    .lane1       (lane_info[1]),
    .lane2       (lane_info[2]),
    .lane3       (lane_info[3]),
    .result      (new_result)
  );

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_fire) begin
      // The output register frees up: refill from skid first to keep order.
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (in_fire) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = new_result;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = new_result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.consumed, out_data_r.code_point};
  assign out_tuser  = out_data_r.status;

  `UTF8D_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r,
                    "skid register holds an item while output register is empty")
  `UTF8D_ASSERT_NOW(a_error_replaces, out_valid_r && (out_data_r.status != ST_VALID),
                    out_data_r.code_point == REPLACEMENT_CP,
                    "error result without replacement code point")
  `UTF8D_ASSERT_NOW(a_consumed_range, out_valid_r,
                    (out_data_r.consumed <= MAX_WINDOW) &&
                    ((out_data_r.consumed != 3'd0) || (out_data_r.status == ST_TRUNC)),
                    "consumed count out of range for status")
  `UTF8D_ASSERT_NEXT(a_accept_shows, in_fire && !out_valid_r, out_valid_r,
                     "accepted item did not reach the output register")

endmodule

/* design/utf8d_lane.sv */
// One byte lane of the UTF-8 decode unit: classifies a window byte.
// Depends on utf8d_pkg.
module utf8d_lane
  import utf8d_pkg::*;
(
  input  logic [7:0]  byte_in,
  output lane_info_t  info
);

  always_comb begin
    info.is_cont = (byte_in >= CONT_LOW) && (byte_in <= CONT_HIGH);
    info.ge_a0   = (byte_in >= 8'hA0);
    info.ge_90   = (byte_in >= 8'h90);
    info.le_9f   = (byte_in <= 8'h9F);
    info.le_8f   = (byte_in <= 8'h8F);
    info.payload = byte_in[5:0] & PAYLOAD_MASK;
  end

endmodule

/* design/utf8d_merge.sv */
// Merge stage of the UTF-8 decode unit: combines the lane findings with the
// lead byte into code point, consumed count and status. Depends on utf8d_pkg.
module utf8d_merge
  import utf8d_pkg::*;
(
  input  logic [7:0]  lead,
  input  logic [2:0]  avail_count,
  input  lane_info_t  lane1,
  input  lane_info_t  lane2,
  input  lane_info_t  lane3,
  output result_t     result
);

  // One plus the run of continuation bytes at positions 1..limit-1.
  function automatic logic [2:0] absorb(input logic [2:0] limit,
                                        input logic c1, input logic c2,
                                        input logic c3);
    logic [2:0] n;
    n = 3'd1;
    if (limit > 3'd1 && c1) begin
      n = 3'd2;
      if (limit > 3'd2 && c2) begin
        n = 3'd3;
        if (limit > 3'd3 && c3) begin
          n = 3'd4;
        end
      end
    end
    return n;
  endfunction

  logic [2:0] avail;
  logic [2:0] seq_len;
  logic [2:0] trunc_limit;
  logic       lo_ok;
  logic       hi_ok;
  logic       b1_ok;

  always_comb begin
    avail = (avail_count > MAX_WINDOW) ? MAX_WINDOW : avail_count;
    trunc_limit = (avail < 3'd3) ? avail : 3'd3;

    if (lead >= 8'hC2 && lead <= 8'hDF) begin
      seq_len = 3'd2;
    end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
      seq_len = 3'd3;
    end else if (lead >= 8'hF0 && lead <= 8'hF4) begin
      seq_len = 3'd4;
    end else begin
      seq_len = 3'd0;
    end

    // Special leads narrow the second-byte range inside 80..BF.
    lo_ok = (lead == LEAD_E0) ? lane1.ge_a0 :
            (lead == LEAD_F0) ? lane1.ge_90 : 1'b1;
    hi_ok = (lead == LEAD_ED) ? lane1.le_9f :
            (lead == LEAD_F4) ? lane1.le_8f : 1'b1;
    b1_ok = lane1.is_cont && lo_ok && hi_ok;

    result.code_point = REPLACEMENT_CP;
    result.consumed   = 3'd0;
    result.status     = ST_TRUNC;

    if (avail == 3'd0) begin
      result.consumed = 3'd0;
      result.status   = ST_TRUNC;
    end else if (!lead[7]) begin
      result.code_point = {14'd0, lead[6:0]};
      result.consumed   = 3'd1;
      result.status     = ST_VALID;
    end else if (seq_len == 3'd0) begin
      result.consumed = absorb(avail, lane1.is_cont, lane2.is_cont, lane3.is_cont);
      result.status   = ST_INVALID;
    end else if (seq_len > avail) begin
      result.consumed = absorb(trunc_limit, lane1.is_cont, lane2.is_cont,
                               lane3.is_cont);
      result.status   = ST_TRUNC;
    end else if (!b1_ok) begin
      result.consumed = absorb(avail, lane1.is_cont, lane2.is_cont, lane3.is_cont);
      result.status   = ST_INVALID;
    end else if (seq_len == 3'd2) begin
      result.code_point = {10'd0, lead[4:0], lane1.payload};
      result.consumed   = 3'd2;
      result.status     = ST_VALID;
    end else if (!lane2.is_cont) begin
      result.status   = ST_INVALID;
      result.consumed = 3'd2;
    end else if (seq_len == 3'd3) begin
      result.code_point = {5'd0, lead[3:0], lane1.payload, lane2.payload};
      result.consumed   = 3'd3;
      result.status     = ST_VALID;
    end else if (!lane3.is_cont) begin
      result.status   = ST_INVALID;
      result.consumed = 3'd3;
    end else begin
      result.code_point = {lead[2:0], lane1.payload, lane2.payload, lane3.payload};
      result.consumed   = 3'd4;
      result.status     = ST_VALID;
    end
  end

endmodule

/* tb/tb_utf8_decode_with_replacement_unit.sv */
// Testbench for the UTF-8 decode unit: directed windows, then random ones.
// Every decoded item is checked against a local model of the decoder.
// Depends on utf8d_pkg and utf8_decode_with_replacement_unit.
module tb_utf8_decode_with_replacement_unit;
  import utf8d_pkg::*;

  localparam int RANDOM_WINDOWS = 620;
  localparam int IDLE_LIMIT     = 1000;
  localparam int DRAIN_CYCLES   = 4;

  // Interesting lead bytes and follow-on bytes, packed eight bits apiece.
  localparam logic [103:0] LEAD_CORNERS = {8'h80, 8'hBF, 8'hC0, 8'hC1, 8'hC2, 8'hDF, 8'hE0,
                                           8'hED, 8'hEF, 8'hF0, 8'hF4, 8'hF5, 8'hFF};
  localparam logic [63:0]  FOLLOW_CORNERS = {8'h7F, 8'h80, 8'h8F, 8'h90, 8'h9F, 8'hA0,
                                             8'hBF, 8'hC0};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // byte0[7:0], byte1[15:8], byte2[23:16],
                                  // byte3[31:24], avail_count[34:32], zero fill
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // code_point[20:0], consumed[23:21]
  logic [1:0]  out_tuser;         // status[1:0]

  result_t     pending_decodes [$];
  int          errors      = 0;
  int          idle_cycles = 0;
  int          burst_left  = 0;
  logic [15:0] cycle_count = '0;

  utf8_decode_with_replacement_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit is_cont(input logic [7:0] b);
    return (b & 8'hC0) == 8'h80;
  endfunction

  // The lead byte plus the continuation bytes that follow it, below limit.
  function automatic logic [2:0] cont_run(input logic [31:0] win, input int limit);
    int n;
    n = 1;
    while (n < limit && n < 4 && is_cont(win[8*n +: 8]))
      n++;
    return n[2:0];
  endfunction

  function automatic result_t decode_window(input logic [31:0] win, input logic [2:0] cnt);
    logic [7:0] lead, b1, b2, b3, lo, hi;
    int         avail, seq_len;
    result_t    r;
    lead = win[7:0];
    b1 = win[15:8];
    b2 = win[23:16];
    b3 = win[31:24];
    avail = (cnt > MAX_WINDOW) ? int'(MAX_WINDOW) : int'(cnt);
    lo = CONT_LOW;
    hi = CONT_HIGH;
    if (lead >= 8'hC2 && lead <= 8'hDF) seq_len = 2;
    else if (lead >= 8'hE0 && lead <= 8'hEF) seq_len = 3;
    else if (lead >= 8'hF0 && lead <= 8'hF4) seq_len = 4;
    else seq_len = 0;
    if (lead == LEAD_E0) lo = 8'hA0;
    if (lead == LEAD_ED) hi = 8'h9F;
    if (lead == LEAD_F0) lo = 8'h90;
    if (lead == LEAD_F4) hi = 8'h8F;

    r.code_point = REPLACEMENT_CP;
    r.consumed   = '0;
    r.status     = ST_INVALID;
    if (avail == 0) begin
      r.status = ST_TRUNC;
    end else if (lead < CONT_LOW) begin
      r.code_point = {13'd0, lead};
      r.consumed = 3'd1;
      r.status = ST_VALID;
    end else if (seq_len == 0) begin
      r.consumed = cont_run(win, avail);
    end else if (seq_len > avail) begin
      // A short window is never range-checked; only the run is absorbed.
      r.consumed = cont_run(win, (avail < 3) ? avail : 3);
      r.status = ST_TRUNC;
    end else if (b1 < lo || b1 > hi) begin
      r.consumed = cont_run(win, avail);
    end else if (seq_len == 2) begin
      r.code_point = {10'd0, lead[4:0], b1[5:0]};
      r.consumed = 3'd2;
      r.status = ST_VALID;
    end else if (!is_cont(b2)) begin
      r.consumed = 3'd2;
    end else if (seq_len == 3) begin
      r.code_point = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
      r.consumed = 3'd3;
      r.status = ST_VALID;
    end else if (!is_cont(b3)) begin
      r.consumed = 3'd3;
    end else begin
      r.code_point = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
      r.consumed = 3'd4;
      r.status = ST_VALID;
    end
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_window(input logic [7:0] b0, b1, b2, b3, input logic [2:0] cnt);
    bit took;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
    end
    in_tdata  <= {5'd0, cnt, b3, b2, b1, b0};
    in_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    burst_left--;
  endtask

  task automatic test_ascii_and_empty();
    send_window(8'h00, 8'h00, 8'h00, 8'h00, 3'd1);
    send_window(8'h7F, 8'hFF, 8'hFF, 8'hFF, 3'd4);
    send_window(8'h41, 8'h80, 8'h80, 8'h80, 3'd0);
    send_window(8'hF0, 8'h90, 8'h80, 8'h80, 3'd7);
    send_window(8'hC3, 8'hA9, 8'h00, 8'h00, 3'd5);
  endtask

  task automatic test_invalid_leads();
    send_window(8'h80, 8'h80, 8'h80, 8'h80, 3'd4);
    send_window(8'hBF, 8'hBF, 8'h41, 8'h80, 3'd3);
    send_window(8'hC0, 8'hAF, 8'h00, 8'h00, 3'd2);
    send_window(8'hC1, 8'hBF, 8'hBF, 8'hBF, 3'd1);
    send_window(8'hF5, 8'h80, 8'h80, 8'h80, 3'd4);
    send_window(8'hFF, 8'hFE, 8'h00, 8'h00, 3'd4);
  endtask

  task automatic test_lead_tables();
    send_window(8'hC2, 8'h80, 8'h00, 8'h00, 3'd2);
    send_window(8'hDF, 8'hBF, 8'h00, 8'h00, 3'd2);
    send_window(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd3);
    send_window(8'hE0, 8'h9F, 8'h80, 8'h00, 3'd3);
    send_window(8'hED, 8'h9F, 8'hBF, 8'h00, 3'd3);
    send_window(8'hED, 8'hA0, 8'h80, 8'h80, 3'd4);
    send_window(8'hEF, 8'hBF, 8'hBF, 8'h00, 3'd3);
    send_window(8'hF0, 8'h8F, 8'hBF, 8'hBF, 3'd4);
    send_window(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd4);
    send_window(8'hF4, 8'h90, 8'h80, 8'h80, 3'd4);
  endtask

  task automatic test_truncation();
    send_window(8'hC3, 8'hA9, 8'h00, 8'h00, 3'd1);
    send_window(8'hE2, 8'h82, 8'h80, 8'h00, 3'd2);
    send_window(8'hE0, 8'h80, 8'h80, 8'h00, 3'd2);
    send_window(8'hF0, 8'h90, 8'h80, 8'h80, 3'd3);
    send_window(8'hF4, 8'h41, 8'h80, 8'h80, 3'd3);
  endtask

  task automatic test_bad_continuation();
    send_window(8'hE2, 8'h41, 8'h80, 8'h00, 3'd3);
    send_window(8'hE2, 8'h82, 8'h41, 8'h00, 3'd3);
    send_window(8'hE2, 8'h82, 8'hC0, 8'h80, 3'd4);
    send_window(8'hF0, 8'h90, 8'h41, 8'h80, 3'd4);
    send_window(8'hF0, 8'h90, 8'h80, 8'h41, 3'd4);
    send_window(8'hF0, 8'h90, 8'h80, 8'hF0, 3'd4);
  endtask

  // Mostly well-formed sequences with random content, some of them broken,
  // plus corner bytes and plain noise.
  task automatic test_random_windows(input int count);
    logic [7:0]  wb [4];
    logic [20:0] cp;
    logic [2:0]  cnt;
    int          kind, len, i;
    for (int k = 0; k < count; k++) begin
      kind = $urandom_range(0, 9);
      for (i = 0; i < 4; i++)
        wb[i] = ($urandom_range(0, 1) == 0) ? {2'b10, 6'($urandom)} : 8'($urandom);
      cnt = 3'($urandom_range(0, 7));
      if (kind < 8) begin
        len = $urandom_range(1, 4);
        case (len)
          1: begin
            wb[0] = 8'($urandom_range(0, 127));
          end
          2: begin
            cp = 21'($urandom_range(21'h80, 21'h7FF));
            wb[0] = {3'b110, cp[10:6]};
            wb[1] = {2'b10, cp[5:0]};
          end
          3: begin
            cp = 21'($urandom_range(21'h800, 21'hFFFF));
            wb[0] = {4'b1110, cp[15:12]};
            wb[1] = {2'b10, cp[11:6]};
            wb[2] = {2'b10, cp[5:0]};
          end
          default: begin
            cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
            wb[0] = {5'b11110, cp[20:18]};
            wb[1] = {2'b10, cp[17:12]};
            wb[2] = {2'b10, cp[11:6]};
            wb[3] = {2'b10, cp[5:0]};
          end
        endcase
        cnt = 3'($urandom_range(len, 7));
        if (kind >= 6) begin
          if (len > 1 && $urandom_range(0, 1) == 0)
            wb[$urandom_range(1, len - 1)] = 8'($urandom);
          else
            cnt = 3'($urandom_range(0, len - 1));
        end
      end else if (kind == 8) begin
        wb[0] = LEAD_CORNERS[8 * $urandom_range(0, 12) +: 8];
        for (i = 1; i < 4; i++)
          wb[i] = FOLLOW_CORNERS[8 * $urandom_range(0, 7) +: 8];
      end else begin
        for (i = 0; i < 4; i++)
          wb[i] = 8'($urandom);
      end
      send_window(wb[0], wb[1], wb[2], wb[3], cnt);
    end
  endtask

  // The receiver cycles through full speed, random stalls, a short periodic
  // stall and long stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 16'd1;
    case (cycle_count[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= (cycle_count[2:0] != 3'd0);
      default: out_tready <= (cycle_count[4:0] >= 5'd20);
    endcase
  end

  // Inputs only change at rising edges, so the falling edge sees exactly
  // what the next rising edge will sample.
  always @(negedge clk) begin
    result_t exp_r;
    bit      in_fire, out_fire;
    if (rst_n) begin
      in_fire  = in_tvalid && in_tready;
      out_fire = out_tvalid && out_tready;
      if (out_fire) begin
        if (pending_decodes.size() == 0) begin
          $display("%0t: result with no window pending: expected none, actual tdata %h tuser %h",
                   $time, out_tdata, out_tuser);
          errors++;
        end else begin
          exp_r = pending_decodes.pop_front();
          if (out_tdata[20:0] !== exp_r.code_point) begin
            $display("%0t: code_point expected %h actual %h", $time, exp_r.code_point,
                     out_tdata[20:0]);
            errors++;
          end
          if (out_tdata[23:21] !== exp_r.consumed) begin
            $display("%0t: consumed expected %0d actual %0d", $time, exp_r.consumed,
                     out_tdata[23:21]);
            errors++;
          end
          if (out_tuser !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_tuser);
            errors++;
          end
        end
      end
      if (in_fire)
        pending_decodes.push_back(decode_window(in_tdata[31:0], in_tdata[34:32]));
      idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT)
      @(negedge clk);
    $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_ascii_and_empty();
    test_invalid_leads();
    test_lead_tables();
    test_truncation();
    test_bad_continuation();
    test_random_windows(RANDOM_WINDOWS);
    in_tvalid <= 1'b0;
    while (pending_decodes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
